// ===== hw/rtl/e2h_pkg.sv =====
package e2h_pkg;

  localparam int unsigned AngW   = 32;
  localparam int unsigned TrigW  = 32;
  localparam int unsigned CordW  = 36;
  localparam int unsigned ZW     = 34;
  localparam int unsigned ProdW  = 34;
  localparam int unsigned SqW    = 62;
  localparam int unsigned SqSteps = 31;

  localparam logic [AngW-1:0] QuarterTurn = 32'h4000_0000;
  localparam logic [AngW-1:0] HalfTurn    = 32'h8000_0000;
  localparam logic signed [CordW-1:0] CordicGain = 36'sd652032874;
  localparam logic signed [TrigW-1:0] Q30One     = 32'sh4000_0000;

  localparam logic [31:0] AtanTable [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                 flip;
    logic signed [ZW-1:0] z;
  } rot_pre_t;

  function automatic rot_pre_t rot_pre(input logic [AngW-1:0] a);
    rot_pre_t        r;
    logic [AngW-1:0] t;
    t      = a + QuarterTurn;
    r.flip = t[AngW-1];
    t      = r.flip ? a + HalfTurn : a;
    r.z    = ZW'(signed'(t));
    return r;
  endfunction

  function automatic logic signed [ProdW-1:0] qmul(input logic signed [TrigW-1:0] a,
                                                   input logic signed [TrigW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = (p + 64'sd536870912) >>> 30;
    return p[ProdW-1:0];
  endfunction

endpackage

// ===== hw/rtl/e2h_cordic_cell.sv =====
module e2h_cordic_cell #(
  parameter int unsigned XW     = 36,
  parameter int unsigned ZBITS  = 34,
  parameter int unsigned SHIFT  = 0,
  parameter bit          VECTOR = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [XW-1:0]    x_i,
  input  logic signed [XW-1:0]    y_i,
  input  logic signed [ZBITS-1:0] z_i,
  output logic signed [XW-1:0]    x_o,
  output logic signed [XW-1:0]    y_o,
  output logic signed [ZBITS-1:0] z_o
);
  import e2h_pkg::*;

  logic signed [XW-1:0]    xs, ys;
  logic signed [ZBITS-1:0] step;
  logic                    ccw;
  logic signed [XW-1:0]    x_d, y_d, x_q, y_q;
  logic signed [ZBITS-1:0] z_d, z_q;

  assign xs   = x_i >>> SHIFT;
  assign ys   = y_i >>> SHIFT;
  assign step = ZBITS'({1'b0, AtanTable[SHIFT]});
  assign ccw  = VECTOR ? (y_i <= 0) : (z_i >= 0);

  always_comb begin
    if (ccw) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - step;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

// ===== hw/rtl/e2h_isqrt_cell.sv =====
module e2h_isqrt_cell #(
  parameter int unsigned VW  = 62,
  parameter int unsigned EXP = 60
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [VW-1:0] v_i,
  input  logic [VW-1:0] r_i,
  output logic [VW-1:0] v_o,
  output logic [VW-1:0] r_o
);
  localparam logic [VW-1:0] Bit = VW'(1) << EXP;

  logic [VW:0]   trial;
  logic [VW-1:0] v_d, r_d, v_q, r_q;

  assign trial = {1'b0, r_i} + {1'b0, Bit};

  always_comb begin
    if ({1'b0, v_i} >= trial) begin
      v_d = v_i - trial[VW-1:0];
      r_d = (r_i >> 1) + Bit;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;
endmodule

// ===== hw/rtl/equatorial_to_horizontal.sv =====
// Channel | Direction | Handshake             | Beat contents
// input   | in        | in_valid_i/in_ready_o | sidereal_angle, star_ra, declination
// output  | out       | out_valid_o/out_ready_i | azimuth, elevation
// config  | in        | APB, pready high      | latitude at 0x0, longitude at 0x4
// One beat is accepted per cycle unless the pipeline holds.
// The latency is set by the rotation cells, the 31 square-root cells and the
// vectoring cells, all in one pipeline that advances together.
// When the output beat is not taken, the whole pipeline holds and in_ready_o falls.
// Reset clears the latitude and longitude registers and all valid flags.
module equatorial_to_horizontal #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] sidereal_angle_i,
  input  logic [31:0] star_ra_i,
  input  logic signed [31:0] declination_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] azimuth_o,
  output logic signed [31:0] elevation_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import e2h_pkg::*;

  localparam int unsigned N      = CORDIC_STEPS;
  localparam int unsigned Depth  = 2 * N + 39;
  localparam int unsigned DlyN   = SqSteps + 1;

  logic [31:0] lat_q, lon_q;
  logic        en;
  logic        vld_q [Depth];

  assign pready = 1'b1;
  assign prdata = paddr[2] ? lon_q : lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= '0;
      lon_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        lon_q <= pwdata;
      end else begin
        lat_q <= pwdata;
      end
    end
  end

  assign en         = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < Depth; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Sine and cosine of latitude, declination and hour angle.
  logic [31:0]             hour;
  rot_pre_t                pre [3];
  logic signed [ZW-1:0]    rz0_q [3];
  logic signed [CordW-1:0] rx [3][N+1];
  logic signed [CordW-1:0] ry [3][N+1];
  logic signed [ZW-1:0]    rz [3][N+1];
  logic [2:0]              flip_q [N+1];

  assign hour   = sidereal_angle_i - lon_q - star_ra_i;
  assign pre[0] = rot_pre(lat_q);
  assign pre[1] = rot_pre(declination_i);
  assign pre[2] = rot_pre(hour);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rz0_q[l]     <= pre[l].z;
        flip_q[0][l] <= pre[l].flip;
      end
      for (int k = 1; k <= N; k++) begin
        flip_q[k] <= flip_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_rlane
    assign rx[l][0] = CordicGain;
    assign ry[l][0] = '0;
    assign rz[l][0] = rz0_q[l];
    for (genvar i = 0; i < N; i++) begin : g_rcell
      e2h_cordic_cell #(
        .XW(CordW), .ZBITS(ZW), .SHIFT(i), .VECTOR(1'b0)
      ) u_cell (
        .clk_i(clk_i), .en_i(en),
        .x_i(rx[l][i]), .y_i(ry[l][i]), .z_i(rz[l][i]),
        .x_o(rx[l][i+1]), .y_o(ry[l][i+1]), .z_o(rz[l][i+1])
      );
    end
  end

  logic signed [TrigW-1:0] sn_q [3];
  logic signed [TrigW-1:0] cs_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sn_q[l] <= flip_q[N][l] ? TrigW'(-ry[l][N]) : TrigW'(ry[l][N]);
        cs_q[l] <= flip_q[N][l] ? TrigW'(-rx[l][N]) : TrigW'(rx[l][N]);
      end
    end
  end

  // Products.
  logic signed [ProdW-1:0] cdch_q, clsd_q, slsd_q, shcd_q;
  logic signed [TrigW-1:0] sl1_q, cl1_q;
  logic signed [ProdW-1:0] clsd2_q, slsd2_q, shcd2_q, slcdch_q, clcdch_q;
  logic signed [CordW-1:0] ax_q, ay_q;
  logic signed [TrigW-1:0] se_q;
  logic signed [ProdW:0]   se_sum;
  logic signed [63:0]      se_sq;

  assign se_sum = (ProdW+1)'(slsd2_q) + (ProdW+1)'(clcdch_q);
  assign se_sq  = 64'(se_q) * 64'(se_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cdch_q   <= qmul(cs_q[1], cs_q[2]);
      clsd_q   <= qmul(cs_q[0], sn_q[1]);
      slsd_q   <= qmul(sn_q[0], sn_q[1]);
      shcd_q   <= qmul(sn_q[2], cs_q[1]);
      sl1_q    <= sn_q[0];
      cl1_q    <= cs_q[0];
      slcdch_q <= qmul(sl1_q, TrigW'(cdch_q));
      clcdch_q <= qmul(cl1_q, TrigW'(cdch_q));
      clsd2_q  <= clsd_q;
      slsd2_q  <= slsd_q;
      shcd2_q  <= shcd_q;
      ax_q     <= CordW'(clsd2_q) - CordW'(slcdch_q);
      ay_q     <= -CordW'(shcd2_q);
      if (se_sum > (ProdW+1)'(Q30One)) begin
        se_q <= Q30One;
      end else if (se_sum < -(ProdW+1)'(Q30One)) begin
        se_q <= -Q30One;
      end else begin
        se_q <= TrigW'(se_sum);
      end
    end
  end

  // Cosine of elevation by square root of one minus the sine squared.
  logic [SqW-1:0]          sv [SqSteps+1];
  logic [SqW-1:0]          sr [SqSteps+1];
  logic signed [CordW-1:0] dax_q [DlyN];
  logic signed [CordW-1:0] day_q [DlyN];
  logic signed [TrigW-1:0] dse_q [DlyN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sv[0]    <= (SqW'(1) << 60) - SqW'(se_sq);
      dax_q[0] <= ax_q;
      day_q[0] <= ay_q;
      dse_q[0] <= se_q;
      for (int k = 1; k < DlyN; k++) begin
        dax_q[k] <= dax_q[k-1];
        day_q[k] <= day_q[k-1];
        dse_q[k] <= dse_q[k-1];
      end
    end
  end

  assign sr[0] = '0;

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    e2h_isqrt_cell #(.VW(SqW), .EXP(60 - 2 * k)) u_cell (
      .clk_i(clk_i), .en_i(en),
      .v_i(sv[k]), .r_i(sr[k]),
      .v_o(sv[k+1]), .r_o(sr[k+1])
    );
  end

  // Arctangents: lane 0 azimuth, lane 1 elevation.
  logic signed [CordW-1:0] vx_in [2];
  logic signed [CordW-1:0] vy_in [2];
  logic signed [CordW-1:0] vx0_q [2];
  logic signed [CordW-1:0] vy0_q [2];
  logic signed [ZW-1:0]    vz0_q [2];
  logic signed [CordW-1:0] vx [2][N+1];
  logic signed [CordW-1:0] vy [2][N+1];
  logic signed [ZW-1:0]    vz [2][N+1];
  logic [1:0]              zero_q [N+1];

  assign vx_in[0] = dax_q[DlyN-1];
  assign vy_in[0] = day_q[DlyN-1];
  assign vx_in[1] = CordW'(sr[SqSteps]);
  assign vy_in[1] = CordW'(dse_q[DlyN-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        zero_q[0][l] <= (vx_in[l] == '0) && (vy_in[l] == '0);
        if (vx_in[l] < 0) begin
          vx0_q[l] <= -vx_in[l];
          vy0_q[l] <= -vy_in[l];
          vz0_q[l] <= ZW'({1'b0, HalfTurn});
        end else begin
          vx0_q[l] <= vx_in[l];
          vy0_q[l] <= vy_in[l];
          vz0_q[l] <= '0;
        end
      end
      for (int k = 1; k <= N; k++) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_vlane
    assign vx[l][0] = vx0_q[l];
    assign vy[l][0] = vy0_q[l];
    assign vz[l][0] = vz0_q[l];
    for (genvar i = 0; i < N; i++) begin : g_vcell
      e2h_cordic_cell #(
        .XW(CordW), .ZBITS(ZW), .SHIFT(i), .VECTOR(1'b1)
      ) u_cell (
        .clk_i(clk_i), .en_i(en),
        .x_i(vx[l][i]), .y_i(vy[l][i]), .z_i(vz[l][i]),
        .x_o(vx[l][i+1]), .y_o(vy[l][i+1]), .z_o(vz[l][i+1])
      );
    end
  end

  logic [31:0]        az_q;
  logic signed [31:0] el_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      az_q <= zero_q[N][0] ? '0 : vz[0][N][31:0];
      if (zero_q[N][1]) begin
        el_q <= '0;
      end else if (vz[1][N] > ZW'(Q30One)) begin
        el_q <= Q30One;
      end else if (vz[1][N] < -ZW'(Q30One)) begin
        el_q <= -Q30One;
      end else begin
        el_q <= vz[1][N][31:0];
      end
    end
  end

  assign azimuth_o   = az_q;
  assign elevation_o = el_q;
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import e2h_pkg::*;

  localparam int unsigned Steps     = 24;
  localparam int unsigned Latency   = 2 * Steps + 39;
  localparam int unsigned WdogLimit = 4000;
  localparam int unsigned LongHold  = 300;
  localparam logic [2:0]  LatAddr   = 3'd0;
  localparam logic [2:0]  LonAddr   = 3'd4;

  typedef struct packed {
    logic [31:0] az;
    logic [31:0] el;
  } horiz_t;

  class horiz_scoreboard;
    logic [31:0] lat;
    logic [31:0] lon;
    horiz_t      expected_q[$];
    int          errors;
    int          n_checked;

    function new();
      lat = '0;
      lon = '0;
      errors = 0;
      n_checked = 0;
    endfunction

    function automatic longint qmul_q30(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void sin_cos(input logic [31:0] a, output longint s,
                                    output longint c);
      logic [31:0] t;
      logic        flip;
      longint      x, y, z, nx;
      t = a + QuarterTurn;
      flip = t[31];
      if (flip) a = a + HalfTurn;
      z = longint'($signed(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < Steps; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - longint'(AtanTable[i]);
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + longint'(AtanTable[i]);
        end
        x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function automatic longint vec_angle(longint y, longint x);
      longint z, nx;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 64'sh8000_0000;
      end
      for (int i = 0; i < Steps; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + longint'(AtanTable[i]);
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - longint'(AtanTable[i]);
        end
        x = nx;
      end
      return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_star(logic [31:0] sid, logic [31:0] ra, logic [31:0] dec);
      logic [31:0] h;
      longint      sl, cl, sd, cd, sh, ch, cdch, ax, ay, se, ce, azv, elv;
      horiz_t      e;
      h = sid - lon - ra;
      sin_cos(lat, sl, cl);
      sin_cos(dec, sd, cd);
      sin_cos(h, sh, ch);
      cdch = qmul_q30(cd, ch);
      ay = -qmul_q30(sh, cd);
      ax = qmul_q30(cl, sd) - qmul_q30(sl, cdch);
      azv = vec_angle(ay, ax);
      se = qmul_q30(sl, sd) + qmul_q30(cl, cdch);
      if (se > (64'sd1 <<< 30)) se = 64'sd1 <<< 30;
      if (se < -(64'sd1 <<< 30)) se = -(64'sd1 <<< 30);
      ce = longint'(int_sqrt((64'd1 << 60) - longint'(se * se)));
      elv = vec_angle(se, ce);
      if (elv > (64'sd1 <<< 30)) elv = 64'sd1 <<< 30;
      if (elv < -(64'sd1 <<< 30)) elv = -(64'sd1 <<< 30);
      e.az = azv[31:0];
      e.el = elv[31:0];
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [31:0] az, logic [31:0] el);
      horiz_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        $error("output beat with no expected result: az=%h el=%h", az, el);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (az !== e.az) begin
        $error("azimuth: expected %h actual %h", e.az, az);
        errors++;
      end
      if (el !== e.el) begin
        $error("elevation: expected %h actual %h", e.el, el);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] sidereal_angle_i = '0;
  logic [31:0] star_ra_i = '0;
  logic [31:0] declination_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] azimuth_o;
  logic [31:0] elevation_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  horiz_scoreboard sb = new();
  int  idle_cycles = 0;
  int  n_sent = 0;
  bit  no_idle = 1'b0;
  bit  long_hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  equatorial_to_horizontal #(.CORDIC_STEPS(Steps)) dut (.*);

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o)
      sb.note_star(sidereal_angle_i, star_ra_i, declination_i);
    if (out_valid_o && out_ready_i)
      sb.check_result(azimuth_o, elevation_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (long_hold_req) begin
        n = LongHold;
        long_hold_req = 1'b0;
      end
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_star(logic [31:0] sid, logic [31:0] ra, logic [31:0] dec);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sidereal_angle_i  <= sid;
    star_ra_i         <= ra;
    declination_i     <= dec;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_observer(logic [31:0] lat, logic [31:0] lon);
    apb_write(LatAddr, lat);
    apb_write(LonAddr, lon);
    sb.lat = lat;
    sb.lon = lon;
  endtask

  function automatic logic [31:0] rand_dec();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
  endfunction

  task automatic directed_stars();
    send_star(32'h0, 32'h0, 32'h0);
    send_star(32'hFFFF_FFFF, 32'h0, 32'h4000_0000);
    send_star(32'h0, 32'hFFFF_FFFF, 32'hC000_0000);
    send_star(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_star(32'h4000_0000, 32'h0, 32'h2000_0000);
    send_star(32'h8000_0000, 32'h0, 32'hE000_0000);
    send_star(32'hC000_0000, 32'h0, 32'h1000_0000);
    send_star(32'h0, 32'h4000_0000, 32'h7FFF_FFFF);
    send_star(32'h0, 32'h8000_0000, 32'h8000_0000);
    send_star(32'h1234_5678, 32'h1234_5678, 32'h4000_0000);
    send_star(32'h1234_5678, 32'h1234_5678, 32'hC000_0000);
    send_star(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
    send_star(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_star(32'h0, 32'h0, 32'h3FFF_FFFF);
    send_star(32'h0, 32'h0, 32'hC000_0001);
  endtask

  task automatic random_stars(int count);
    for (int i = 0; i < count; i++)
      send_star($urandom(), $urandom(), rand_dec());
  endtask

  initial begin
    logic [31:0] lat_set[6];
    logic [31:0] lon_set[6];
    lat_set = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h0, 32'h8000_0000, 32'h0};
    lon_set = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'h0, 32'h0};
    lat_set[3] = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    lon_set[3] = $urandom();
    lat_set[5] = $urandom();
    lon_set[5] = $urandom();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_stars();
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      set_observer(lat_set[p], lon_set[p]);
      if (p == 1 || p == 4) directed_stars();
      no_idle = (p == 2);
      if (p == 3) long_hold_req = 1'b1;
      random_stars(75);
    end
    no_idle = 1'b0;
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    $display("Converted %0d stars over six observer settings; %0d results checked.",
             n_sent, sb.n_checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
